[rtl/core/ultrasonic_range_fan_switch_macros.svh]
// Assertion macros for the ultrasonic range fan switch.
// Used by the top level only; needs nothing else.
`ifndef ULTRASONIC_RANGE_FAN_SWITCH_MACROS_SVH
`define ULTRASONIC_RANGE_FAN_SWITCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define URSW_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("ursw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define URSW_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("ursw assertion failed");

`endif

[rtl/core/ursw_pkg.sv]
// Shared types and constants for the ultrasonic range fan switch.
// No dependencies; imported by every module of the block.
`default_nettype none

package ursw_pkg;

    // Fixed register widths
    localparam int TRIG_W  = 8;
    localparam int PAUSE_W = 21;
    localparam int STEP_W  = 16;
    localparam int THR_W   = 10;
    localparam int DATA_W  = 21;
    localparam int INDEX_W = 3;

    // Register indexes
    localparam logic [INDEX_W-1:0] REG_TRIGGER_TICKS = 3'd0;
    localparam logic [INDEX_W-1:0] REG_PAUSE_TICKS   = 3'd1;
    localparam logic [INDEX_W-1:0] REG_CM_STEP_X100  = 3'd2;
    localparam logic [INDEX_W-1:0] REG_ON_CM         = 3'd3;
    localparam logic [INDEX_W-1:0] REG_OFF_CM        = 3'd4;

    // Register reset values
    localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST = 8'd80;
    localparam logic [PAUSE_W-1:0] PAUSE_TICKS_RST   = 21'd1600000;
    localparam logic [STEP_W-1:0]  CM_STEP_RST       = 16'd46647;
    localparam logic [THR_W-1:0]   ON_CM_RST         = 10'd75;
    localparam logic [THR_W-1:0]   OFF_CM_RST        = 10'd10;

    // Range arithmetic: each tick weighs 100, the step is never below 101
    localparam logic [STEP_W-1:0]  STEP_MIN    = 16'd101;
    localparam logic [STEP_W-1:0]  TICK_WEIGHT = 16'd100;

    // Measurement phases
    localparam logic [1:0] PH_TRIGGER = 2'd0;
    localparam logic [1:0] PH_WAIT    = 2'd1;
    localparam logic [1:0] PH_MEASURE = 2'd2;
    localparam logic [1:0] PH_PAUSE   = 2'd3;

    typedef struct packed {
        logic [TRIG_W-1:0]  trigger_ticks;
        logic [PAUSE_W-1:0] pause_ticks;
        logic [STEP_W-1:0]  cm_step_x100;
        logic [THR_W-1:0]   on_cm;
        logic [THR_W-1:0]   off_cm;
    } cfg_t;

    typedef struct packed {
        logic trigger_out;
        logic switch_on;
        logic distance_valid;
    } flags_t;

endpackage

`default_nettype wire

[rtl/core/ultrasonic_range_fan_switch.sv]
// Ultrasonic range fan switch top level; uses ursw_pkg, ursw_cfg, ursw_ranger,
// ursw_outreg and the assertion macro header.
// The result of a tick appears at the output in the cycle after it is accepted.
// Throughput: one tick per cycle when out_ready is high, set by the single result register.
// Reset: asynchronous active low; registers return to defaults, sequencer to trigger phase.
`default_nettype none
`include "ultrasonic_range_fan_switch_macros.svh"

module ultrasonic_range_fan_switch #(
    parameter int DISTANCE_BITS    = 10,
    parameter int PHASE_COUNT_BITS = 21
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          echo_level,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               trigger_out,
    output logic                               switch_on,
    output logic [DISTANCE_BITS-1:0]           distance_cm,
    output logic                               distance_valid,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ursw_pkg::INDEX_W-1:0]  cfg_index,
    input  wire logic [ursw_pkg::DATA_W-1:0]   cfg_data
);
    import ursw_pkg::*;

    cfg_t                     cfg;
    flags_t                   res_flags;
    flags_t                   out_flags;
    logic [DISTANCE_BITS-1:0] res_dist;
    logic                     accept;

    assign accept = in_valid && in_ready;

    ursw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ursw_ranger #(
        .DISTANCE_BITS    (DISTANCE_BITS),
        .PHASE_COUNT_BITS (PHASE_COUNT_BITS)
    ) u_ranger (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .echo_level (echo_level),
        .cfg        (cfg),
        .flags      (res_flags),
        .distance   (res_dist)
    );

    ursw_outreg #(
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .flags_d   (res_flags),
        .dist_d    (res_dist),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .flags_q   (out_flags),
        .dist_q    (distance_cm)
    );

    assign trigger_out    = out_flags.trigger_out;
    assign switch_on      = out_flags.switch_on;
    assign distance_valid = out_flags.distance_valid;

    // A stalled result blocks new items
    `URSW_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, out_valid && !out_ready, !in_ready)
    // Every accepted item yields a result next cycle
    `URSW_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_valid)
    // A measurement never completes on a trigger tick
    `URSW_ASSERT_NOW(a_trigger_not_done, clk, rst_n, out_valid, !(trigger_out && distance_valid))

endmodule

`default_nettype wire

[rtl/core/ursw_cfg.sv]
// Configuration register file for the ultrasonic range fan switch.
// Depends on ursw_pkg.
`default_nettype none

module ursw_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ursw_pkg::INDEX_W-1:0]  cfg_index,
    input  wire logic [ursw_pkg::DATA_W-1:0]   cfg_data,
    output ursw_pkg::cfg_t                     cfg
);
    import ursw_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always able to take a write
    assign cfg_ready = 1'b1;

    // Decode the write; unknown indexes drop the data
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TRIGGER_TICKS: cfg_next.trigger_ticks = cfg_data[TRIG_W-1:0];
                REG_PAUSE_TICKS:   cfg_next.pause_ticks   = cfg_data[PAUSE_W-1:0];
                REG_CM_STEP_X100:  cfg_next.cm_step_x100  = cfg_data[STEP_W-1:0];
                REG_ON_CM:         cfg_next.on_cm         = cfg_data[THR_W-1:0];
                REG_OFF_CM:        cfg_next.off_cm        = cfg_data[THR_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_ticks <= TRIGGER_TICKS_RST;
            cfg_reg.pause_ticks   <= PAUSE_TICKS_RST;
            cfg_reg.cm_step_x100  <= CM_STEP_RST;
            cfg_reg.on_cm         <= ON_CM_RST;
            cfg_reg.off_cm        <= OFF_CM_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/core/ursw_ranger.sv]
// Measurement sequencer: trigger, echo wait, tick-to-cm accumulation, pause,
// and the hysteresis switch. Depends on ursw_pkg.
`default_nettype none

module ursw_ranger #(
    parameter int DISTANCE_BITS    = 10,
    parameter int PHASE_COUNT_BITS = 21
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire logic                      echo_level,
    input  ursw_pkg::cfg_t                 cfg,
    output ursw_pkg::flags_t               flags,
    output logic [DISTANCE_BITS-1:0]       distance
);
    import ursw_pkg::*;

    localparam logic [DISTANCE_BITS-1:0] DIST_MAX = {DISTANCE_BITS{1'b1}};
    localparam int CMP_W   = (DISTANCE_BITS > THR_W) ? DISTANCE_BITS : THR_W;
    localparam int PAUSE_CMP_W = (PHASE_COUNT_BITS > PAUSE_W) ? PHASE_COUNT_BITS : PAUSE_W;

    logic [1:0]                  phase_reg, phase_next;
    logic [PHASE_COUNT_BITS-1:0] ticks_reg, ticks_next;
    logic                        echo_prev_reg, echo_prev_next;
    logic [STEP_W-1:0]           frac_reg, frac_next;
    logic [DISTANCE_BITS-1:0]    cm_reg, cm_next;
    logic [DISTANCE_BITS-1:0]    last_reg, last_next;
    logic                        state_reg, state_next;

    logic [PHASE_COUNT_BITS-1:0] ticks_inc;
    logic [TRIG_W-1:0]           trig_len;
    logic [STEP_W-1:0]           step_eff;
    logic [STEP_W:0]             frac_sum;
    logic                        frac_wrap;
    logic                        cm_sat;
    logic [DISTANCE_BITS-1:0]    dist_final;
    logic                        trig;
    logic                        dvalid;

    // Shared arithmetic for the phase counter and the cm accumulator
    assign ticks_inc  = ticks_reg + PHASE_COUNT_BITS'(1);
    assign trig_len   = (cfg.trigger_ticks == '0) ? TRIG_W'(1) : cfg.trigger_ticks;
    assign step_eff   = (cfg.cm_step_x100 < STEP_MIN) ? STEP_MIN : cfg.cm_step_x100;
    assign frac_sum   = {1'b0, frac_reg} + {1'b0, TICK_WEIGHT};
    assign frac_wrap  = (frac_sum >= {1'b0, step_eff});
    assign cm_sat     = (cm_reg >= DIST_MAX);
    // Round up when a partial centimetre remains
    assign dist_final = cm_reg + DISTANCE_BITS'((!cm_sat) && (frac_reg != '0));

    // Advance the sequencer on each accepted tick
    always_comb
    begin
        phase_next     = phase_reg;
        ticks_next     = ticks_reg;
        echo_prev_next = echo_prev_reg;
        frac_next      = frac_reg;
        cm_next        = cm_reg;
        last_next      = last_reg;
        state_next     = state_reg;
        trig           = 1'b0;
        dvalid         = 1'b0;
        if (step)
        begin
            echo_prev_next = echo_level;
            unique case (phase_reg)
                PH_TRIGGER:
                begin
                    trig       = 1'b1;
                    ticks_next = ticks_inc;
                    if (ticks_inc >= PHASE_COUNT_BITS'(trig_len))
                    begin
                        phase_next = PH_WAIT;
                        ticks_next = '0;
                    end
                end
                PH_WAIT:
                begin
                    // Rising edge: restart and count this tick as the first
                    if (echo_level && !echo_prev_reg)
                    begin
                        frac_next  = TICK_WEIGHT;
                        cm_next    = '0;
                        phase_next = PH_MEASURE;
                    end
                end
                PH_MEASURE:
                begin
                    if (echo_level)
                    begin
                        if (!cm_sat)
                        begin
                            if (frac_wrap)
                            begin
                                frac_next = STEP_W'(frac_sum - {1'b0, step_eff});
                                cm_next   = cm_reg + DISTANCE_BITS'(1);
                            end
                            else
                            begin
                                frac_next = frac_sum[STEP_W-1:0];
                            end
                        end
                    end
                    else
                    begin
                        // Falling edge: publish and apply hysteresis, on wins
                        last_next = dist_final;
                        dvalid    = 1'b1;
                        if (CMP_W'(dist_final) >= CMP_W'(cfg.on_cm))
                        begin
                            state_next = 1'b1;
                        end
                        else if (CMP_W'(dist_final) <= CMP_W'(cfg.off_cm))
                        begin
                            state_next = 1'b0;
                        end
                        ticks_next = '0;
                        phase_next = (cfg.pause_ticks == '0) ? PH_TRIGGER : PH_PAUSE;
                    end
                end
                default:
                begin
                    // Pause phase
                    ticks_next = ticks_inc;
                    if (PAUSE_CMP_W'(ticks_inc) >= PAUSE_CMP_W'(cfg.pause_ticks))
                    begin
                        phase_next = PH_TRIGGER;
                        ticks_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TRIGGER;
            ticks_reg     <= '0;
            echo_prev_reg <= 1'b0;
            frac_reg      <= '0;
            cm_reg        <= '0;
            last_reg      <= '0;
            state_reg     <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            ticks_reg     <= ticks_next;
            echo_prev_reg <= echo_prev_next;
            frac_reg      <= frac_next;
            cm_reg        <= cm_next;
            last_reg      <= last_next;
            state_reg     <= state_next;
        end
    end

    // Result of this tick, registered downstream
    assign flags.trigger_out    = trig;
    assign flags.switch_on      = state_next;
    assign flags.distance_valid = dvalid;
    assign distance             = last_next;

endmodule

`default_nettype wire

[rtl/core/ursw_outreg.sv]
// Result register between the sequencer and the output channel.
// Depends on ursw_pkg.
`default_nettype none

module ursw_outreg #(
    parameter int DISTANCE_BITS = 10
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      load,
    input  ursw_pkg::flags_t               flags_d,
    input  wire logic [DISTANCE_BITS-1:0]  dist_d,
    output logic                           in_ready,
    input  wire logic                      out_ready,
    output logic                           out_valid,
    output ursw_pkg::flags_t               flags_q,
    output logic [DISTANCE_BITS-1:0]       dist_q
);
    import ursw_pkg::*;

    logic                     valid_reg, valid_next;
    flags_t                   flags_reg;
    logic [DISTANCE_BITS-1:0] dist_reg;

    // Take a new item when empty or when the held one leaves this cycle
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds until the next load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg <= flags_d;
            dist_reg  <= dist_d;
        end
    end

    assign out_valid = valid_reg;
    assign flags_q   = flags_reg;
    assign dist_q    = dist_reg;

endmodule

`default_nettype wire

[bench/tb_ultrasonic_range_fan_switch.sv]
// Self-checking testbench for the ultrasonic range fan switch.
// Depends on ursw_pkg and the ultrasonic_range_fan_switch top level only.
// A tick-by-tick range predictor checks every output item in order.
module tb_ultrasonic_range_fan_switch;
    timeunit 1ns;
    timeprecision 1ps;

    import ursw_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int ROUND_TICKS = 30;
    localparam logic [9:0] DIST_MAX = 10'h3FF;
    // Index with no register behind it; the write is dropped
    localparam logic [INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic       trigger_out;
        logic       switch_on;
        logic [9:0] distance_cm;
        logic       distance_valid;
    } tick_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                echo_level = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                trigger_out;
    logic                switch_on;
    logic [9:0]          distance_cm;
    logic                distance_valid;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [INDEX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0]   cfg_data = '0;

    // Range predictor state and its copy of the registers
    cfg_t                range_cfg;
    logic [1:0]          range_phase;
    logic [PAUSE_W-1:0]  range_phase_ticks;
    logic                range_echo_prev;
    logic [16:0]         range_fraction;
    logic [9:0]          range_cm_count;
    logic [9:0]          range_last_cm;
    logic                range_switch;

    tick_result_t        expected_outputs[$];
    bit                  burst_mode = 1'b0;
    int unsigned         fail_count = 0;
    int unsigned         ticks_sent = 0;
    int unsigned         outputs_checked = 0;
    int unsigned         distances_seen = 0;
    int unsigned         config_writes = 0;
    int unsigned         stall_cycles = 0;

    ultrasonic_range_fan_switch dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .echo_level     (echo_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .trigger_out    (trigger_out),
        .switch_on      (switch_on),
        .distance_cm    (distance_cm),
        .distance_valid (distance_valid),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Add one echo tick of weight 100; bump the cm count at each full step
    function automatic void add_echo_tick();
        logic [STEP_W-1:0] step;
        step = (range_cfg.cm_step_x100 < STEP_MIN) ? STEP_MIN : range_cfg.cm_step_x100;
        if (range_cm_count >= DIST_MAX)
            return;
        range_fraction = range_fraction + TICK_WEIGHT;
        if (range_fraction >= step)
        begin
            range_fraction = range_fraction - step;
            range_cm_count = range_cm_count + 1'b1;
        end
    endfunction

    // Advance the ranging sequence by one tick and return its output item
    function automatic tick_result_t predict_tick(input logic echo);
        tick_result_t r;
        logic [8:0]   trig_len;
        logic [10:0]  rounded_cm;
        r.trigger_out = 1'b0;
        r.distance_valid = 1'b0;
        case (range_phase)
            PH_TRIGGER:
            begin
                trig_len = (range_cfg.trigger_ticks == '0) ? 9'd1 : range_cfg.trigger_ticks;
                r.trigger_out = 1'b1;
                range_phase_ticks = range_phase_ticks + 1'b1;
                if (range_phase_ticks >= trig_len)
                begin
                    range_phase = PH_WAIT;
                    range_phase_ticks = '0;
                end
            end
            PH_WAIT:
            begin
                if (echo && !range_echo_prev)
                begin
                    range_fraction = '0;
                    range_cm_count = '0;
                    add_echo_tick();
                    range_phase = PH_MEASURE;
                end
            end
            PH_MEASURE:
            begin
                if (echo)
                    add_echo_tick();
                else
                begin
                    // Round up a partial centimetre, never past the maximum
                    rounded_cm = {1'b0, range_cm_count};
                    if (rounded_cm < DIST_MAX && range_fraction != 0)
                        rounded_cm = rounded_cm + 1'b1;
                    range_last_cm = rounded_cm[9:0];
                    r.distance_valid = 1'b1;
                    if (range_last_cm >= range_cfg.on_cm)
                        range_switch = 1'b1;
                    else if (range_last_cm <= range_cfg.off_cm)
                        range_switch = 1'b0;
                    range_phase_ticks = '0;
                    range_phase = (range_cfg.pause_ticks == '0) ? PH_TRIGGER : PH_PAUSE;
                end
            end
            default:
            begin
                range_phase_ticks = range_phase_ticks + 1'b1;
                if (range_phase_ticks >= range_cfg.pause_ticks)
                begin
                    range_phase = PH_TRIGGER;
                    range_phase_ticks = '0;
                end
            end
        endcase
        range_echo_prev = echo;
        r.switch_on = range_switch;
        r.distance_cm = range_last_cm;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [9:0] want,
                                        input logic [9:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Send one tick, with a random gap first unless in a burst
    task automatic send_tick(input logic echo);
        if (!burst_mode && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 34)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        echo_level <= echo;
        do
            @(posedge clk);
        while (!in_ready);
        expected_outputs.push_back(predict_tick(echo));
        ticks_sent++;
    endtask

    // Hold off the sender until every predicted item has come out
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
        wait_results_drained();
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_TRIGGER_TICKS: range_cfg.trigger_ticks = data[TRIG_W-1:0];
            REG_PAUSE_TICKS:   range_cfg.pause_ticks   = data[PAUSE_W-1:0];
            REG_CM_STEP_X100:  range_cfg.cm_step_x100  = data[STEP_W-1:0];
            REG_ON_CM:         range_cfg.on_cm         = data[THR_W-1:0];
            REG_OFF_CM:        range_cfg.off_cm        = data[THR_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        config_writes++;
    endtask

    task automatic write_all_regs(input logic [DATA_W-1:0] trig, input logic [DATA_W-1:0] pause,
                                  input logic [DATA_W-1:0] step, input logic [DATA_W-1:0] on_thr,
                                  input logic [DATA_W-1:0] off_thr);
        write_reg(REG_TRIGGER_TICKS, trig);
        write_reg(REG_PAUSE_TICKS, pause);
        write_reg(REG_CM_STEP_X100, step);
        write_reg(REG_ON_CM, on_thr);
        write_reg(REG_OFF_CM, off_thr);
    endtask

    // One well-formed measurement: noise until waiting, clean rise, high_len highs, fall
    task automatic run_measurement(input int unsigned high_len);
        while (range_phase != PH_WAIT)
            send_tick(range_phase == PH_MEASURE ? 1'b0 : 1'($urandom_range(1)));
        if (range_echo_prev)
            send_tick(1'b0);
        repeat ($urandom_range(0, 3)) send_tick(1'b0);
        repeat (high_len) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // Reset values: the default trigger is 80 ticks long
    task automatic test_reset_values();
        repeat (12) send_tick(1'($urandom_range(1)));
    endtask

    // Zero trigger, zero pause, step below minimum, both thresholds met, echo high early
    task automatic test_corner_cases();
        write_all_regs(21'd0, 21'd0, 21'd0, 21'd3, 21'd5);
        write_reg(REG_UNUSED, 21'h1F_FFFF);
        run_measurement(1);
        // Echo already high when waiting starts: needs a fall before the rise
        while (range_phase != PH_WAIT)
            send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        repeat (3) send_tick(1'b1);
        send_tick(1'b0);
        run_measurement(6);
    endtask

    // Widest trigger, longest pause, coarsest step, thresholds at the ends
    task automatic test_register_extremes();
        write_all_regs(21'd255, 21'h1F_FFFF, 21'h1F_FFFF, 21'd1023, 21'd0);
        run_measurement(20);
        repeat (10) send_tick(1'($urandom_range(1)));
        write_reg(REG_PAUSE_TICKS, 21'd1);
        write_reg(REG_ON_CM, 21'd0);
        write_reg(REG_TRIGGER_TICKS, 21'd2);
        run_measurement(3);
    endtask

    // Finest step with both thresholds at the top: a short echo switches off,
    // then a long one saturates the count in a burst and the on test wins
    task automatic test_saturation();
        write_all_regs(21'd1, 21'd0, 21'd101, 21'd1023, 21'd1023);
        run_measurement(5);
        burst_mode = 1'b1;
        run_measurement(1040);
        burst_mode = 1'b0;
    endtask

    // Random settings per round, mostly clean measurements with some noise
    task automatic test_random_traffic();
        int unsigned round_start;
        for (int round = 0; round < 2; round++)
        begin
            write_all_regs(DATA_W'(($urandom_range(5) == 0) ? $urandom_range(7, 40)
                                                            : $urandom_range(1, 4)),
                           DATA_W'($urandom_range(0, 6)), DATA_W'($urandom_range(101, 2500)),
                           DATA_W'($urandom_range(0, 40)), DATA_W'($urandom_range(0, 40)));
            burst_mode = (round == 1);
            round_start = ticks_sent;
            while (ticks_sent - round_start < ROUND_TICKS)
            begin
                if ($urandom_range(9) < 8)
                    run_measurement($urandom_range(1, 30));
                else
                    repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)));
                if ($urandom_range(14) == 0)
                    wait_results_drained();
            end
            burst_mode = 1'b0;
        end
    endtask

    // Receiver side: random stalls except during a burst
    always @(posedge clk)
        out_ready <= rst_n && (burst_mode || $urandom_range(99) >= 34);

    // Compare each output item with the oldest prediction
    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_outputs.size() == 0)
            begin
                $error("output item with no prediction pending");
                fail_count++;
            end
            else
            begin
                want = expected_outputs.pop_front();
                check_field("trigger_out", 10'(want.trigger_out), 10'(trigger_out));
                check_field("switch_on", 10'(want.switch_on), 10'(switch_on));
                check_field("distance_cm", want.distance_cm, distance_cm);
                check_field("distance_valid", 10'(want.distance_valid), 10'(distance_valid));
                outputs_checked++;
                if (want.distance_valid)
                    distances_seen++;
            end
        end
    end

    // Count cycles in which no channel moves an item
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        range_cfg = '{TRIGGER_TICKS_RST, PAUSE_TICKS_RST, CM_STEP_RST, ON_CM_RST, OFF_CM_RST};
        range_phase = PH_TRIGGER;
        range_phase_ticks = '0;
        range_echo_prev = 1'b0;
        range_fraction = '0;
        range_cm_count = '0;
        range_last_cm = '0;
        range_switch = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_corner_cases();
        test_register_extremes();
        test_saturation();
        test_random_traffic();

        wait_results_drained();
        repeat (8) @(posedge clk);
        $display("Sent %0d ticks across %0d register writes; checked %0d output items.",
                 ticks_sent, config_writes, outputs_checked);
        $display("Completed %0d distance measurements, including saturation and both thresholds.",
                 distances_seen);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
